// File: rtl/core/tsvu_pkg.sv
// Shared types and constants of the tab-separated field unescaper.
package tsvu_pkg;

    localparam int RES_MAX = 4;
    localparam int CNT_W   = $clog2(RES_MAX + 1);
    localparam int IDX_W   = $clog2(RES_MAX);

    typedef enum logic [2:0] {
        K_BYTE = 3'd0,
        K_MORE = 3'd1,
        K_LINE = 3'd2,
        K_DATA = 3'd3,
        K_ERR  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        M_START     = 4'd0,
        M_START_BS  = 4'd1,
        M_START_BSN = 4'd2,
        M_PLAIN     = 4'd3,
        M_PLAIN_ESC = 4'd4,
        M_ARRAY     = 4'd5,
        M_STR       = 4'd6,
        M_STR_ESC   = 4'd7,
        M_AFTER     = 4'd8,
        M_DISCARD   = 4'd9
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       nul;
    } t_result;

    // Results caused by one input byte: entry 0 goes out first.
    typedef struct packed {
        t_result [RES_MAX-1:0] r;
        logic    [CNT_W-1:0]   n;
    } t_res_set;

    localparam logic [7:0] C_TAB  = 8'h09;
    localparam logic [7:0] C_LF   = 8'h0A;
    localparam logic [7:0] C_LBRK = 8'h5B;
    localparam logic [7:0] C_RBRK = 8'h5D;
    localparam logic [7:0] C_LBRC = 8'h7B;
    localparam logic [7:0] C_RBRC = 8'h7D;
    localparam logic [7:0] C_SQ   = 8'h27;
    localparam logic [7:0] C_DQ   = 8'h22;
    localparam logic [7:0] C_N    = 8'h4E;
    localparam logic [7:0] C_BSL  = 8'h5C;

endpackage

// File: rtl/core/tsvu_step.sv
// Per-byte parser step: next mode, next depth and the results of one byte.
module tsvu_step
    import tsvu_pkg::*;
#(
    parameter int MAX_DEPTH = 15
) (
    input  t_mode                              i_mode,
    input  logic [$clog2(MAX_DEPTH+1)-1:0]     i_depth,
    input  logic [7:0]                         i_data,
    input  logic                               i_is_arr,
    input  logic                               i_last,
    output t_mode                              o_mode,
    output logic [$clog2(MAX_DEPTH+1)-1:0]     o_depth,
    output t_res_set                           o_res
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_LIM = DEPTH_W'(MAX_DEPTH);

    typedef struct packed {
        t_res_set res;
        t_mode    mode;
    } t_pb;

    function automatic t_res_set push(input t_res_set s, input t_kind k,
                                      input logic [7:0] b, input logic nl);
        t_res_set o;
        o = s;
        if (s.n < CNT_W'(RES_MAX)) begin
            o.r[s.n[IDX_W-1:0]] = '{kind: k, data: b, nul: nl};
            o.n = s.n + CNT_W'(1);
        end
        return o;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] u;
        unique case (c)
            8'h6E:   u = 8'h0A;  // n
            8'h74:   u = 8'h09;  // t
            8'h30:   u = 8'h00;  // 0
            8'h72:   u = 8'h0D;  // r
            8'h62:   u = 8'h08;  // b
            8'h66:   u = 8'h0C;  // f
            default: u = c;
        endcase
        return u;
    endfunction

    // A byte of a plain field, shared by several modes.
    function automatic t_pb plain_byte(input t_res_set s, input t_mode m,
                                       input logic [7:0] c, input logic last);
        t_pb o;
        o.res  = s;
        o.mode = m;
        if (c == C_TAB) begin
            o.res = push(o.res, K_MORE, 8'h00, 1'b0);
            if (last) begin
                o.res = push(o.res, K_DATA, 8'h00, 1'b0);
            end
            o.mode = M_START;
        end else if (c == C_LF) begin
            o.res  = push(o.res, last ? K_DATA : K_LINE, 8'h00, 1'b0);
            o.mode = M_START;
        end else if (c == C_BSL) begin
            if (last) begin
                o.res = push(o.res, K_DATA, 8'h00, 1'b0);
            end else begin
                o.mode = M_PLAIN_ESC;
            end
        end else begin
            o.res  = push(o.res, K_BYTE, c, 1'b0);
            o.mode = M_PLAIN;
            if (last) begin
                o.res = push(o.res, K_DATA, 8'h00, 1'b0);
            end
        end
        return o;
    endfunction

    t_res_set           s;
    t_mode              m;
    logic [DEPTH_W-1:0] d;
    t_pb                pb;
    logic               err;

    always_comb begin
        s   = '0;
        m   = i_mode;
        d   = i_depth;
        pb  = '0;
        err = 1'b0;
        unique case (i_mode)
            M_START_BS: begin
                if (i_data == C_N) begin
                    if (i_last) begin
                        s = push(s, K_DATA, 8'h00, 1'b1);
                    end else begin
                        m = M_START_BSN;
                    end
                end else begin
                    s = push(s, K_BYTE, unescape(i_data), 1'b0);
                    m = M_PLAIN;
                    if (i_last) begin
                        s = push(s, K_DATA, 8'h00, 1'b0);
                    end
                end
            end
            M_START_BSN: begin
                if (i_data == C_TAB) begin
                    s = push(s, K_MORE, 8'h00, 1'b1);
                    if (i_last) begin
                        s = push(s, K_DATA, 8'h00, 1'b0);
                    end
                    m = M_START;
                end else if (i_data == C_LF) begin
                    s = push(s, i_last ? K_DATA : K_LINE, 8'h00, 1'b1);
                    m = M_START;
                end else begin
                    s  = push(s, K_BYTE, C_BSL, 1'b0);
                    s  = push(s, K_BYTE, C_N, 1'b0);
                    pb = plain_byte(s, m, i_data, i_last);
                    s  = pb.res;
                    m  = pb.mode;
                end
            end
            M_PLAIN: begin
                pb = plain_byte(s, m, i_data, i_last);
                s  = pb.res;
                m  = pb.mode;
            end
            M_PLAIN_ESC: begin
                if (i_data == C_N) begin
                    s = push(s, K_BYTE, C_BSL, 1'b0);
                    s = push(s, K_BYTE, C_N, 1'b0);
                end else begin
                    s = push(s, K_BYTE, unescape(i_data), 1'b0);
                end
                m = M_PLAIN;
                if (i_last) begin
                    s = push(s, K_DATA, 8'h00, 1'b0);
                end
            end
            M_ARRAY: begin
                if (i_data == C_SQ) begin
                    s   = push(s, K_BYTE, C_DQ, 1'b0);
                    m   = M_STR;
                    err = i_last;
                end else if (i_data == C_LBRK) begin
                    if (d >= DEPTH_LIM) begin
                        err = 1'b1;
                    end else begin
                        d   = d + DEPTH_W'(1);
                        s   = push(s, K_BYTE, C_LBRC, 1'b0);
                        err = i_last;
                    end
                end else if (i_data == C_RBRK) begin
                    s = push(s, K_BYTE, C_RBRC, 1'b0);
                    if (d != '0) begin
                        d = d - DEPTH_W'(1);
                    end
                    if (d == '0) begin
                        m = M_AFTER;
                        if (i_last) begin
                            s = push(s, K_DATA, 8'h00, 1'b0);
                        end
                    end else begin
                        err = i_last;
                    end
                end else begin
                    s   = push(s, K_BYTE, i_data, 1'b0);
                    err = i_last;
                end
            end
            M_STR: begin
                if (i_data == C_SQ) begin
                    s = push(s, K_BYTE, C_DQ, 1'b0);
                    m = M_ARRAY;
                end else if (i_data == C_DQ) begin
                    s = push(s, K_BYTE, C_BSL, 1'b0);
                    s = push(s, K_BYTE, C_DQ, 1'b0);
                end else if (i_data == C_BSL) begin
                    m = M_STR_ESC;
                end else begin
                    s = push(s, K_BYTE, i_data, 1'b0);
                end
                err = i_last;
            end
            M_STR_ESC: begin
                if (i_data == C_BSL) begin
                    s = push(s, K_BYTE, C_BSL, 1'b0);
                    s = push(s, K_BYTE, C_BSL, 1'b0);
                end else begin
                    s = push(s, K_BYTE, unescape(i_data), 1'b0);
                end
                m   = M_STR;
                err = i_last;
            end
            M_AFTER: begin
                if (i_data == C_TAB) begin
                    s = push(s, K_MORE, 8'h00, 1'b0);
                    if (i_last) begin
                        s = push(s, K_DATA, 8'h00, 1'b0);
                    end
                    m = M_START;
                end else if (i_data == C_LF) begin
                    s = push(s, i_last ? K_DATA : K_LINE, 8'h00, 1'b0);
                    m = M_START;
                end else begin
                    err = 1'b1;
                end
            end
            M_DISCARD: begin
                m = M_DISCARD;
            end
            default: begin
                // Start of a field.
                if (i_data == C_BSL) begin
                    if (i_last) begin
                        s = push(s, K_DATA, 8'h00, 1'b0);
                    end else begin
                        m = M_START_BS;
                    end
                end else if (i_is_arr && i_data == C_LBRK) begin
                    s   = push(s, K_BYTE, C_LBRC, 1'b0);
                    d   = DEPTH_W'(1);
                    m   = M_ARRAY;
                    err = i_last;
                end else begin
                    pb = plain_byte(s, m, i_data, i_last);
                    s  = pb.res;
                    m  = pb.mode;
                end
            end
        endcase

        if (err) begin
            s = push(s, K_ERR, 8'h00, 1'b0);
            m = M_DISCARD;
            d = '0;
        end
        // The end of a buffer always leaves the parser ready for the next one.
        if (i_last) begin
            m = M_START;
            d = '0;
        end
    end

    assign o_mode  = m;
    assign o_depth = d;
    assign o_res   = s;

endmodule

// File: rtl/core/tsv_field_unescape_array_convert.sv
// Top level of the tab-separated field parser with array literal conversion.
//
// The slave channel takes one byte of a text buffer per transfer: tdata is
// the byte, tuser flags an array column (sampled on a field's first byte) and
// tlast marks the buffer's final byte. The master channel gives one result per
// transfer: tdata is the value byte (zero unless the kind is a value byte),
// tuser holds the result kind and the null flag, and tlast marks the final
// result caused by one input byte.
// The parser state is updated in the cycle a byte is accepted, and that
// byte's results (zero to four) land in a four-entry result buffer. The first
// result is offered in the cycle after the byte's transfer. The buffer drains
// one result per cycle while the receiver is ready. A new byte is accepted
// while the last buffered result leaves, so bytes stream at one per cycle
// when each byte gives at most one result and the receiver is ready.
// When the receiver stalls, the buffer holds and the slave side stops taking
// bytes once the buffer has more than one result or the final one is held.
// Reset clears the buffer and returns the parser to the start of a field with
// no open brackets.
module tsv_field_unescape_array_convert
    import tsvu_pkg::*;
#(
    parameter int MAX_DEPTH = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tuser,   // [0] column_is_array
    input  logic       i_s_axis_tlast,   // is_last_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] o_m_axis_tuser,   // [2:0] result_kind, [3] null_field
    output logic       o_m_axis_tlast    // last_of_run
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    t_mode                 r_mode,  n_mode;
    logic [DEPTH_W-1:0]    r_depth, n_depth;
    t_result [RES_MAX-1:0] r_buf,   n_buf;
    logic [CNT_W-1:0]      r_cnt,   n_cnt;

    t_mode                 step_mode;
    logic [DEPTH_W-1:0]    step_depth;
    t_res_set              step_res;
    logic                  s_acc;
    logic                  m_pop;

    tsvu_step #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_step (
        .i_mode   (r_mode),
        .i_depth  (r_depth),
        .i_data   (i_s_axis_tdata),
        .i_is_arr (i_s_axis_tuser),
        .i_last   (i_s_axis_tlast),
        .o_mode   (step_mode),
        .o_depth  (step_depth),
        .o_res    (step_res)
    );

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign m_pop           = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_m_axis_tready);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_mode  = r_mode;
        n_depth = r_depth;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        if (s_acc) begin
            // The buffer is empty or emptying, so the new results replace it.
            n_mode  = step_mode;
            n_depth = step_depth;
            n_buf   = step_res.r;
            n_cnt   = step_res.n;
        end else if (m_pop) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                n_buf[i] = r_buf[i+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_START;
            r_depth <= '0;
            r_cnt   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_m_axis_tdata = r_buf[0].data;
    assign o_m_axis_tuser = {r_buf[0].nul, r_buf[0].kind};
    assign o_m_axis_tlast = (r_cnt == CNT_W'(1));

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RES_MAX))
        else $error("result buffer count above its size");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth above its limit");

    a_buf_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tlast) |=> (r_mode == M_START && r_depth == '0))
        else $error("parser not back at field start after buffer end");

    a_discard_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_DISCARD) |-> (r_depth == '0))
        else $error("depth kept while discarding");

    a_marker_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_buf[0].kind != K_BYTE) |-> (o_m_axis_tdata == 8'h00))
        else $error("field end or error carries a data byte");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the tab-separated field unescaper with array literal conversion.
module tb_top
    import tsvu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DEPTH = 15;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [7:0] data;
        logic       arr;
        logic       fin;
        bit         hold;
    } t_tsv_byte;

    typedef struct {
        t_kind      kind;
        logic [7:0] data;
        logic       nul;
        logic       fin;
    } t_field_res;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = 8'h00;
    logic       s_arr = 1'b0;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic [3:0] o_m_axis_tuser;
    logic       o_m_axis_tlast;

    t_tsv_byte  byte_feed[$];
    t_tsv_byte  cur_buf[$];
    t_field_res field_results[$];
    int         feed_total = 1;
    int         taken = 0;
    int         phase = 0;
    int         errors = 0;
    int         idle_cycles = 0;
    logic       field_arr = 1'b0;
    bit         field_first = 1'b0;

    // Parser state as the block should hold it.
    t_mode      scan_st = M_START;
    int         open_lvl = 0;
    t_field_res run_res[RES_MAX];
    int         run_n;

    string text_pool  = "abcxyzN019 ,.'\"{}]";
    string esc_pool   = "ntr0bfN\\x\t'";
    string elem_pool  = ",0123abc \t\n\"";
    string str_pool   = "abcN \t\n[]{},";
    string sesc_pool  = "\\bfrnt0N'x\"";

    tsv_field_unescape_array_convert #(
        .MAX_DEPTH(MAX_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_arr),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void add_res(input t_kind kind, input logic [7:0] data, input logic nul);
        if (run_n < RES_MAX) begin
            run_res[run_n].kind = kind;
            run_res[run_n].data = data;
            run_res[run_n].nul  = nul;
            run_n++;
        end
    endfunction

    function automatic logic [7:0] esc_value(input logic [7:0] c);
        case (c)
            "n": return 8'h0A;
            "t": return 8'h09;
            "0": return 8'h00;
            "r": return 8'h0D;
            "b": return 8'h08;
            "f": return 8'h0C;
            default: return c;
        endcase
    endfunction

    function automatic void flag_error();
        add_res(K_ERR, 8'h00, 1'b0);
        scan_st = M_DISCARD;
        open_lvl = 0;
    endfunction

    function automatic void end_tab(input logic nul, input logic lst);
        add_res(K_MORE, 8'h00, nul);
        if (lst)
            add_res(K_DATA, 8'h00, 1'b0);
        scan_st = M_START;
    endfunction

    function automatic void end_line(input logic nul, input logic lst);
        add_res(lst ? K_DATA : K_LINE, 8'h00, nul);
        scan_st = M_START;
    endfunction

    function automatic void plain_char(input logic [7:0] c, input logic lst);
        if (c == C_TAB) begin
            end_tab(1'b0, lst);
        end else if (c == C_LF) begin
            end_line(1'b0, lst);
        end else if (c == C_BSL) begin
            // A backslash on the buffer's last byte is dropped.
            if (lst)
                add_res(K_DATA, 8'h00, 1'b0);
            else
                scan_st = M_PLAIN_ESC;
        end else begin
            add_res(K_BYTE, c, 1'b0);
            scan_st = M_PLAIN;
            if (lst)
                add_res(K_DATA, 8'h00, 1'b0);
        end
    endfunction

    function automatic void plain_esc(input logic [7:0] c, input logic lst);
        if (c == C_N) begin
            add_res(K_BYTE, C_BSL, 1'b0);
            add_res(K_BYTE, C_N, 1'b0);
        end else begin
            add_res(K_BYTE, esc_value(c), 1'b0);
        end
        scan_st = M_PLAIN;
        if (lst)
            add_res(K_DATA, 8'h00, 1'b0);
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic arr, input logic lst);
        t_field_res r;
        run_n = 0;
        case (scan_st)
            M_START_BS: begin
                if (c == C_N) begin
                    if (lst)
                        add_res(K_DATA, 8'h00, 1'b1);
                    else
                        scan_st = M_START_BSN;
                end else begin
                    plain_esc(c, lst);
                end
            end
            M_START_BSN: begin
                if (c == C_TAB) begin
                    end_tab(1'b1, lst);
                end else if (c == C_LF) begin
                    end_line(1'b1, lst);
                end else begin
                    add_res(K_BYTE, C_BSL, 1'b0);
                    add_res(K_BYTE, C_N, 1'b0);
                    plain_char(c, lst);
                end
            end
            M_PLAIN: plain_char(c, lst);
            M_PLAIN_ESC: plain_esc(c, lst);
            M_ARRAY: begin
                if (c == C_SQ) begin
                    add_res(K_BYTE, C_DQ, 1'b0);
                    scan_st = M_STR;
                    if (lst)
                        flag_error();
                end else if (c == C_LBRK) begin
                    if (open_lvl >= MAX_DEPTH) begin
                        flag_error();
                    end else begin
                        open_lvl++;
                        add_res(K_BYTE, C_LBRC, 1'b0);
                        if (lst)
                            flag_error();
                    end
                end else if (c == C_RBRK) begin
                    add_res(K_BYTE, C_RBRC, 1'b0);
                    if (open_lvl > 0)
                        open_lvl--;
                    if (open_lvl == 0) begin
                        scan_st = M_AFTER;
                        if (lst)
                            add_res(K_DATA, 8'h00, 1'b0);
                    end else if (lst) begin
                        flag_error();
                    end
                end else begin
                    add_res(K_BYTE, c, 1'b0);
                    if (lst)
                        flag_error();
                end
            end
            M_STR: begin
                if (c == C_SQ) begin
                    add_res(K_BYTE, C_DQ, 1'b0);
                    scan_st = M_ARRAY;
                end else if (c == C_DQ) begin
                    add_res(K_BYTE, C_BSL, 1'b0);
                    add_res(K_BYTE, C_DQ, 1'b0);
                end else if (c == C_BSL) begin
                    scan_st = M_STR_ESC;
                end else begin
                    add_res(K_BYTE, c, 1'b0);
                end
                if (lst)
                    flag_error();
            end
            M_STR_ESC: begin
                if (c == C_BSL) begin
                    add_res(K_BYTE, C_BSL, 1'b0);
                    add_res(K_BYTE, C_BSL, 1'b0);
                end else begin
                    add_res(K_BYTE, (c == C_N) ? c : esc_value(c), 1'b0);
                end
                scan_st = M_STR;
                if (lst)
                    flag_error();
            end
            M_AFTER: begin
                if (c == C_TAB)
                    end_tab(1'b0, lst);
                else if (c == C_LF)
                    end_line(1'b0, lst);
                else
                    flag_error();
            end
            M_DISCARD: ;
            default: begin
                if (c == C_BSL) begin
                    if (lst)
                        add_res(K_DATA, 8'h00, 1'b0);
                    else
                        scan_st = M_START_BS;
                end else if (arr && c == C_LBRK) begin
                    add_res(K_BYTE, C_LBRC, 1'b0);
                    open_lvl = 1;
                    scan_st = M_ARRAY;
                    if (lst)
                        flag_error();
                end else begin
                    plain_char(c, lst);
                end
            end
        endcase
        if (lst) begin
            scan_st = M_START;
            open_lvl = 0;
        end
        for (int i = 0; i < run_n; i++) begin
            r = run_res[i];
            r.fin = (i == run_n - 1);
            field_results.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void begin_field(input logic arr);
        field_arr = arr;
        field_first = 1'b1;
    endfunction

    // The array flag only matters on a field's first byte, so the rest get noise.
    function automatic void put(input logic [7:0] b);
        t_tsv_byte it;
        it.data = b;
        it.arr  = field_first ? field_arr : logic'($urandom_range(0, 1));
        it.fin  = 1'b0;
        it.hold = 1'b0;
        field_first = 1'b0;
        cur_buf.push_back(it);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic void end_buf();
        t_tsv_byte it;
        it = cur_buf.pop_back();
        it.fin = 1'b1;
        cur_buf.push_back(it);
        while (cur_buf.size() != 0)
            byte_feed.push_back(cur_buf.pop_front());
    endfunction

    function automatic logic [7:0] pick(input string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic void add_plain();
        int n;
        int sel;
        n = $urandom_range(0, 8);
        repeat (n) begin
            sel = $urandom_range(0, 19);
            if (sel < 3) begin
                put(C_BSL);
                put(pick(esc_pool));
            end else if (sel < 4) begin
                put(8'($urandom_range(0, 255)));
            end else begin
                put(pick(text_pool));
            end
        end
    endfunction

    function automatic void add_array();
        int lvl;
        int lim;
        int steps;
        int act;
        int n;
        int k;
        lim = ($urandom_range(0, 9) == 0) ? MAX_DEPTH : $urandom_range(1, 4);
        lvl = 1;
        steps = 0;
        put(C_LBRK);
        // The deepest legal nesting is opened in one go.
        if (lim == MAX_DEPTH) begin
            repeat (MAX_DEPTH - 1) put(C_LBRK);
            lvl = MAX_DEPTH;
        end
        while (lvl > 0) begin
            act = (steps > 12) ? 9 : $urandom_range(0, 9);
            if (act < 2 && lvl < lim) begin
                put(C_LBRK);
                lvl++;
            end else if (act < 5) begin
                put(pick(elem_pool));
            end else if (act < 8) begin
                put(C_SQ);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    k = $urandom_range(0, 9);
                    if (k < 2) begin
                        put(C_BSL);
                        put(pick(sesc_pool));
                    end else if (k < 3) begin
                        put(C_DQ);
                    end else if (k < 4) begin
                        k = $urandom_range(0, 255);
                        put((k == C_SQ || k == C_BSL) ? 8'h7A : 8'(k));
                    end else begin
                        put(pick(str_pool));
                    end
                end
                put(C_SQ);
            end else begin
                put(C_RBRK);
                lvl--;
            end
            steps++;
        end
    endfunction

    function automatic void add_buffer();
        int nf;
        int sel;
        int n;
        bit stop;
        nf = $urandom_range(1, 6);
        stop = 1'b0;
        for (int f = 0; f < nf && !stop; f++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                begin_field(logic'($urandom_range(0, 1)));
                add_plain();
            end else if (sel < 45) begin
                begin_field(logic'($urandom_range(0, 1)));
                put(C_BSL);
                put(C_N);
            end else if (sel < 75) begin
                begin_field(1'b1);
                add_array();
                if ($urandom_range(0, 9) == 0)
                    put(pick(text_pool));
            end else if (sel < 80) begin
                // One bracket too many; the rest of the buffer is discarded.
                begin_field(1'b1);
                repeat (MAX_DEPTH + 1) put(C_LBRK);
                put("a");
                stop = 1'b1;
            end else if (sel < 85) begin
                // The buffer ends inside an open bracket or string.
                begin_field(1'b1);
                put(C_LBRK);
                if ($urandom_range(0, 1) == 1)
                    put(C_SQ);
                put("q");
                stop = 1'b1;
            end else if (sel < 93) begin
                begin_field(logic'($urandom_range(0, 1)));
                n = $urandom_range(1, 6);
                repeat (n) put(8'($urandom_range(0, 255)));
            end else begin
                begin_field(logic'($urandom_range(0, 1)));
            end
            if (!stop) begin
                if (f < nf - 1) begin
                    put(($urandom_range(0, 9) < 7) ? C_TAB : C_LF);
                end else begin
                    case ($urandom_range(0, 2))
                        1: put(C_TAB);
                        2: put(C_LF);
                        default: ;
                    endcase
                end
            end
        end
        if (cur_buf.size() == 0)
            put(C_LF);
        end_buf();
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        t_tsv_byte nxt;
        int idle_pct;
        idle_pct = (phase == 0) ? 27 : (phase == 1) ? 74 : 0;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready)
                predict_byte(s_data, s_arr, s_last);
            if (!s_valid || o_s_axis_tready) begin
                if (byte_feed.size() != 0
                        && !(byte_feed[0].hold && field_results.size() != 0)
                        && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = byte_feed.pop_front();
                    phase = (taken * 3) / feed_total;
                    taken++;
                    s_valid <= 1'b1;
                    s_data  <= nxt.data;
                    s_arr   <= nxt.arr;
                    s_last  <= nxt.fin;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver and monitor

    always @(posedge i_clk) begin
        int idle_pct;
        idle_pct = (phase == 0) ? 74 : (phase == 1) ? 27 : 0;
        if (!i_rst_n)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_field_res want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (field_results.size() == 0) begin
                $display("%0t: unexpected result: kind %0d byte %h null %b last %b",
                         $time, o_m_axis_tuser[2:0], o_m_axis_tdata, o_m_axis_tuser[3],
                         o_m_axis_tlast);
                errors++;
            end else begin
                want = field_results.pop_front();
                if (o_m_axis_tuser[2:0] !== want.kind || o_m_axis_tdata !== want.data
                        || o_m_axis_tuser[3] !== want.nul || o_m_axis_tlast !== want.fin) begin
                    $display({"%0t: mismatch: expected kind %0d byte %h null %b last %b,",
                              " got kind %0d byte %h null %b last %b"},
                             $time, want.kind, want.data, want.nul, want.fin,
                             o_m_axis_tuser[2:0], o_m_axis_tdata, o_m_axis_tuser[3],
                             o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        t_tsv_byte it;

        // Null field ending in a tab, escapes, byte extremes, backslash-N inside
        // a field, and a tab on the buffer's last byte.
        begin_field(1'b0);
        put_text("\\N\t");
        begin_field(1'b0);
        put_text("\\t");
        put(8'hFF);
        put(8'h00);
        put_text("\\N\t");
        end_buf();
        // Array string with quote and escapes, closed, then a newline as last byte.
        begin_field(1'b1);
        put_text("['\"\\n\\\\']\n");
        end_buf();
        // Dangling backslash.
        begin_field(1'b0);
        put_text("a\\");
        end_buf();
        // Null marker at the very end of a buffer.
        begin_field(1'b0);
        put_text("\\N");
        end_buf();
        // Stray byte after a closed array.
        begin_field(1'b1);
        put_text("[]x");
        end_buf();
        // Unterminated array.
        begin_field(1'b1);
        put_text("[[");
        end_buf();

        while (byte_feed.size() < 300)
            add_buffer();

        feed_total = byte_feed.size();
        // The sender waits for the result stream to drain at each phase change.
        for (int i = 1; i < 3; i++) begin
            it = byte_feed[i * feed_total / 3];
            it.hold = 1'b1;
            byte_feed[i * feed_total / 3] = it;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed.size() != 0 || s_valid || field_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        errors += field_results.size();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: tsv_field_unescape_array_convert.f
rtl/core/tsvu_pkg.sv
rtl/core/tsvu_step.sv
rtl/core/tsv_field_unescape_array_convert.sv
verif/tb_top.sv
